[rtl/core/joystick_to_differential_drive_core_assert.svh]
// ----------------------------------------------------------------------------
// Joystick mixer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_TO_DIFFERENTIAL_DRIVE_CORE_ASSERT_SVH
`define JOYSTICK_TO_DIFFERENTIAL_DRIVE_CORE_ASSERT_SVH

// Overlapping implication: cons must hold in the same cycle as ante.
`define JDD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("joystick mixer assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define JDD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("joystick mixer assertion failed");

`endif

[rtl/core/jdd_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick mixer package
// Widths, constants, stage types and the CORDIC angle table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdd_pkg;

	// Default parameter values.
	localparam int TOP_SPEED_DEF    = 100;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ANG_TAB_LEN      = 24;

	// Field widths.
	localparam int IN_W    = 16;
	localparam int MAG_W   = 15;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SPEED_W = 9;

	// Square root: 23 result bits from a 47-bit radicand.
	localparam int REM_W        = 47;
	localparam int SQRT_STEPS   = 23;
	localparam int SQRT_W       = 23;
	localparam int SQRT_TOP_BIT = 2 * (SQRT_STEPS - 1);
	localparam int NORM_SHIFT   = 16;

	// CORDIC datapath.
	localparam int CORD_W = 34;
	localparam int ANG_W  = 32;
	localparam int MUL_W  = 31;

	// Numeric constants.
	localparam int ONE_Q14            = 16384;
	localparam logic [ANG_W-1:0] QUARTER_Q30 = 32'h4000_0000;
	localparam int PROD_SHIFT         = 52;
	localparam int SPEED_POS_MAX      = 255;
	localparam int SPEED_NEG_MAX      = 256;

	// Per-word side information that rides along the pipeline.
	typedef struct packed {
		logic neg;
		logic yzero;
		logic xzero;
		logic xpos;
	} jdd_flags_t;

	// Square root and CORDIC state of one word.
	typedef struct packed {
		logic [REM_W-1:0]         rem;
		logic [REM_W-1:0]         root;
		logic signed [CORD_W-1:0] cx;
		logic signed [CORD_W-1:0] cy;
		logic signed [ANG_W-1:0]  z;
	} jdd_iter_t;

	// atan(2^-i) in quarter turns, Q30.
	function automatic logic [ANG_W-1:0] atan_q30(input int idx);
		logic [ANG_W-1:0] a;
		case (idx)
			0:  a = 32'd536870912;
			1:  a = 32'd316933406;
			2:  a = 32'd167458907;
			3:  a = 32'd85004756;
			4:  a = 32'd42667331;
			5:  a = 32'd21354465;
			6:  a = 32'd10679838;
			7:  a = 32'd5340245;
			8:  a = 32'd2670163;
			9:  a = 32'd1335087;
			10: a = 32'd667544;
			11: a = 32'd333772;
			12: a = 32'd166886;
			13: a = 32'd83443;
			14: a = 32'd41722;
			15: a = 32'd20861;
			16: a = 32'd10430;
			17: a = 32'd5215;
			18: a = 32'd2608;
			19: a = 32'd1304;
			20: a = 32'd652;
			21: a = 32'd326;
			22: a = 32'd163;
			23: a = 32'd81;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[rtl/core/jdd_front.sv]
// ----------------------------------------------------------------------------
// Joystick mixer front end
// Clamps the stick, squares the magnitudes and seeds the iterative stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdd_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic signed [jdd_pkg::IN_W-1:0]        stick_x,
	input  logic signed [jdd_pkg::IN_W-1:0]        stick_y,
	output logic                                   out_valid,
	output jdd_pkg::jdd_iter_t                     out_dat,
	output jdd_pkg::jdd_flags_t                    out_flags
);

	localparam logic signed [jdd_pkg::IN_W-1:0] POS_ONE = jdd_pkg::IN_W'(jdd_pkg::ONE_Q14);
	localparam logic signed [jdd_pkg::IN_W-1:0] NEG_ONE = -POS_ONE;

	logic signed [jdd_pkg::IN_W-1:0] xc_c, yc_c;
	logic [jdd_pkg::MAG_W-1:0]       ax_c, ay_c;
	jdd_pkg::jdd_flags_t             flg_c;

	logic                            vld_s1, vld_s2, vld_s3;
	logic [jdd_pkg::MAG_W-1:0]       ax_s1, ay_s1, ax_s2, ay_s2;
	logic [jdd_pkg::SQ_W-1:0]        sqx_s2, sqy_s2;
	jdd_pkg::jdd_flags_t             flg_s1, flg_s2, flg_s3;
	jdd_pkg::jdd_iter_t              dat_s3;

	// Clamp to plus or minus one and split into magnitude and flags.
	always_comb begin
		xc_c = (stick_x > POS_ONE) ? POS_ONE : ((stick_x < NEG_ONE) ? NEG_ONE : stick_x);
		yc_c = (stick_y > POS_ONE) ? POS_ONE : ((stick_y < NEG_ONE) ? NEG_ONE : stick_y);
		ax_c = jdd_pkg::MAG_W'(xc_c[jdd_pkg::IN_W-1] ? -xc_c : xc_c);
		ay_c = jdd_pkg::MAG_W'(yc_c[jdd_pkg::IN_W-1] ? -yc_c : yc_c);
		flg_c.neg   = yc_c[jdd_pkg::IN_W-1];
		flg_c.yzero = (yc_c == '0);
		flg_c.xzero = (xc_c == '0);
		flg_c.xpos  = !xc_c[jdd_pkg::IN_W-1] && (xc_c != '0);
	end

	// Valid bits of the three front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Payload: magnitudes, then squares, then the seeded iteration state.
	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1  <= ax_c;
			ay_s1  <= ay_c;
			flg_s1 <= flg_c;

			sqx_s2 <= jdd_pkg::SQ_W'(ax_s1 * ax_s1);
			sqy_s2 <= jdd_pkg::SQ_W'(ay_s1 * ay_s1);
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			flg_s2 <= flg_s1;

			dat_s3.rem  <= jdd_pkg::REM_W'({(jdd_pkg::SQ_W + 1)'(sqx_s2)
				+ (jdd_pkg::SQ_W + 1)'(sqy_s2), {jdd_pkg::NORM_SHIFT{1'b0}}});
			dat_s3.root <= '0;
			dat_s3.cx   <= jdd_pkg::CORD_W'({ax_s2, {jdd_pkg::NORM_SHIFT{1'b0}}});
			dat_s3.cy   <= jdd_pkg::CORD_W'({ay_s2, {jdd_pkg::NORM_SHIFT{1'b0}}});
			dat_s3.z    <= '0;
			flg_s3      <= flg_s2;
		end
	end

	assign out_valid = vld_s3;
	assign out_dat   = dat_s3;
	assign out_flags = flg_s3;

endmodule

[rtl/core/jdd_sqrt_step.sv]
// ----------------------------------------------------------------------------
// Joystick mixer square root step
// One restoring step of the bit-pair integer square root.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdd_sqrt_step #(
	parameter int BIT_POS = jdd_pkg::SQRT_TOP_BIT
) (
	input  logic [jdd_pkg::REM_W-1:0] rem_in,
	input  logic [jdd_pkg::REM_W-1:0] root_in,
	output logic [jdd_pkg::REM_W-1:0] rem_out,
	output logic [jdd_pkg::REM_W-1:0] root_out
);

	localparam logic [jdd_pkg::REM_W-1:0] BIT_VAL = jdd_pkg::REM_W'(1) << BIT_POS;

	logic [jdd_pkg::REM_W-1:0] trial;

	// Subtract the trial value when it fits and set this root bit.
	always_comb begin
		trial = root_in + BIT_VAL;
		if (rem_in >= trial) begin
			rem_out  = rem_in - trial;
			root_out = (root_in >> 1) + BIT_VAL;
		end else begin
			rem_out  = rem_in;
			root_out = root_in >> 1;
		end
	end

endmodule

[rtl/core/jdd_cordic_step.sv]
// ----------------------------------------------------------------------------
// Joystick mixer CORDIC step
// One vectoring rotation with a fixed shift and table angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdd_cordic_step #(
	parameter int STEP = 0
) (
	input  logic signed [jdd_pkg::CORD_W-1:0] cx_in,
	input  logic signed [jdd_pkg::CORD_W-1:0] cy_in,
	input  logic signed [jdd_pkg::ANG_W-1:0]  z_in,
	output logic signed [jdd_pkg::CORD_W-1:0] cx_out,
	output logic signed [jdd_pkg::CORD_W-1:0] cy_out,
	output logic signed [jdd_pkg::ANG_W-1:0]  z_out
);

	localparam logic signed [jdd_pkg::ANG_W-1:0] ANG = $signed(jdd_pkg::atan_q30(STEP));

	logic signed [jdd_pkg::CORD_W-1:0] dx, dy;

	// Rotate toward the x axis; the arithmetic shifts round toward minus infinity.
	always_comb begin
		dx = cy_in >>> STEP;
		dy = cx_in >>> STEP;
		if (!cy_in[jdd_pkg::CORD_W-1] && (cy_in != '0)) begin
			cx_out = cx_in + dx;
			cy_out = cy_in - dy;
			z_out  = z_in + ANG;
		end else begin
			cx_out = cx_in - dx;
			cy_out = cy_in + dy;
			z_out  = z_in - ANG;
		end
	end

endmodule

[rtl/core/jdd_iter.sv]
// ----------------------------------------------------------------------------
// Joystick mixer iterative pipeline
// Square root and CORDIC run side by side, one step per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdd_iter #(
	parameter int CORDIC_STEPS = jdd_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  jdd_pkg::jdd_iter_t  in_dat,
	input  jdd_pkg::jdd_flags_t in_flags,
	output logic                out_valid,
	output jdd_pkg::jdd_iter_t  out_dat,
	output jdd_pkg::jdd_flags_t out_flags
);

	localparam int NSTG = (CORDIC_STEPS > jdd_pkg::SQRT_STEPS) ? CORDIC_STEPS
		: jdd_pkg::SQRT_STEPS;

	// Element 0 is the stage input; elements 1 to NSTG are registers.
	logic                vld_sn [NSTG+1];
	jdd_pkg::jdd_iter_t  dat_sn [NSTG+1];
	jdd_pkg::jdd_flags_t flg_sn [NSTG+1];

	assign vld_sn[0] = in_valid;
	assign dat_sn[0] = in_dat;
	assign flg_sn[0] = in_flags;

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		logic [jdd_pkg::REM_W-1:0]         rem_nx, root_nx;
		logic signed [jdd_pkg::CORD_W-1:0] cx_nx, cy_nx;
		logic signed [jdd_pkg::ANG_W-1:0]  z_nx;

		// Square root step, or hold once all root bits are done.
		if (k < jdd_pkg::SQRT_STEPS) begin : g_sqrt
			jdd_sqrt_step #(
				.BIT_POS(jdd_pkg::SQRT_TOP_BIT - 2 * k)
			) u_sqrt (
				.rem_in  (dat_sn[k].rem),
				.root_in (dat_sn[k].root),
				.rem_out (rem_nx),
				.root_out(root_nx)
			);
		end else begin : g_sqrt_hold
			assign rem_nx  = dat_sn[k].rem;
			assign root_nx = dat_sn[k].root;
		end

		// CORDIC step, or hold once the configured steps are done.
		if (k < CORDIC_STEPS) begin : g_cordic
			jdd_cordic_step #(
				.STEP(k)
			) u_cordic (
				.cx_in (dat_sn[k].cx),
				.cy_in (dat_sn[k].cy),
				.z_in  (dat_sn[k].z),
				.cx_out(cx_nx),
				.cy_out(cy_nx),
				.z_out (z_nx)
			);
		end else begin : g_cordic_hold
			assign cx_nx = dat_sn[k].cx;
			assign cy_nx = dat_sn[k].cy;
			assign z_nx  = dat_sn[k].z;
		end

		// Valid bit of this stage.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k+1] <= 1'b0;
			end else if (en) begin
				vld_sn[k+1] <= vld_sn[k];
			end
		end

		// Payload of this stage.
		always_ff @(posedge clk) begin
			if (en) begin
				dat_sn[k+1].rem  <= rem_nx;
				dat_sn[k+1].root <= root_nx;
				dat_sn[k+1].cx   <= cx_nx;
				dat_sn[k+1].cy   <= cy_nx;
				dat_sn[k+1].z    <= z_nx;
				flg_sn[k+1]      <= flg_sn[k];
			end
		end
	end

	assign out_valid = vld_sn[NSTG];
	assign out_dat   = dat_sn[NSTG];
	assign out_flags = flg_sn[NSTG];

endmodule

[rtl/core/jdd_back.sv]
// ----------------------------------------------------------------------------
// Joystick mixer back end
// Scales the norm by speed and angle, floors and saturates both speeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdd_back #(
	parameter int TOP_SPEED = jdd_pkg::TOP_SPEED_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  jdd_pkg::jdd_iter_t                  in_dat,
	input  jdd_pkg::jdd_flags_t                 in_flags,
	output logic                                out_valid,
	output logic signed [jdd_pkg::SPEED_W-1:0]  left_speed,
	output logic signed [jdd_pkg::SPEED_W-1:0]  right_speed,
	output jdd_pkg::jdd_flags_t                 out_flags
);

	localparam int QW = jdd_pkg::SQRT_W + $clog2(TOP_SPEED + 1);
	localparam int PW = QW + jdd_pkg::MUL_W;
	localparam int MW = PW - jdd_pkg::PROD_SHIFT + 1;
	localparam int ME = (MW > 10) ? MW : 10;
	localparam logic [QW-1:0] MAX_SPD = QW'(TOP_SPEED);
	localparam logic signed [jdd_pkg::ANG_W-1:0] QUARTER_S = $signed(jdd_pkg::QUARTER_Q30);

	logic [jdd_pkg::MUL_W-1:0] t_c;
	logic [PW-1:0]             prod_c, full_c;

	logic                       vld_s1, vld_s2, vld_s3;
	logic [QW-1:0]              q_s1;
	logic [jdd_pkg::MUL_W-1:0]  t_s1;
	logic [PW-1:0]              lp_s2, rp_s2;
	jdd_pkg::jdd_flags_t        flg_s1, flg_s2, flg_s3;
	logic [jdd_pkg::SPEED_W-1:0] left_s3, right_s3;

	// Floor of a signed product over 2^52, saturated to the speed range.
	function automatic logic [jdd_pkg::SPEED_W-1:0] to_speed(input logic [PW-1:0] p,
		input logic neg, input logic zero);
		logic [ME-1:0]               m;
		logic [jdd_pkg::SPEED_W-1:0] mag;
		logic [jdd_pkg::SPEED_W-1:0] v;
		m = ME'(p[PW-1:jdd_pkg::PROD_SHIFT])
			+ ME'(neg && (p[jdd_pkg::PROD_SHIFT-1:0] != '0));
		if (neg) begin
			mag = (m > ME'(jdd_pkg::SPEED_NEG_MAX))
				? jdd_pkg::SPEED_W'(jdd_pkg::SPEED_NEG_MAX) : m[jdd_pkg::SPEED_W-1:0];
			v = ~mag + 1'b1;
		end else begin
			mag = (m > ME'(jdd_pkg::SPEED_POS_MAX))
				? jdd_pkg::SPEED_W'(jdd_pkg::SPEED_POS_MAX) : m[jdd_pkg::SPEED_W-1:0];
			v = mag;
		end
		if (zero) begin
			v = '0;
		end
		return v;
	endfunction

	// Angle scale: a quarter turn when x is zero, else the clamped CORDIC angle.
	always_comb begin
		if (in_flags.xzero) begin
			t_c = jdd_pkg::QUARTER_Q30[jdd_pkg::MUL_W-1:0];
		end else if (in_dat.z[jdd_pkg::ANG_W-1]) begin
			t_c = '0;
		end else if (in_dat.z > QUARTER_S) begin
			t_c = jdd_pkg::QUARTER_Q30[jdd_pkg::MUL_W-1:0];
		end else begin
			t_c = in_dat.z[jdd_pkg::MUL_W-1:0];
		end
	end

	// Scaled and unscaled products of the speed-weighted norm.
	always_comb begin
		prod_c = PW'(q_s1) * PW'(t_s1);
		full_c = PW'(q_s1) << (jdd_pkg::MUL_W - 1);
	end

	// Valid bits of the three back stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Payload: weighted norm, then motor products, then the final speeds.
	always_ff @(posedge clk) begin
		if (en) begin
			q_s1   <= MAX_SPD * QW'(in_dat.root[jdd_pkg::SQRT_W-1:0]);
			t_s1   <= t_c;
			flg_s1 <= in_flags;

			lp_s2  <= flg_s1.xpos ? full_c : prod_c;
			rp_s2  <= flg_s1.xpos ? prod_c : full_c;
			flg_s2 <= flg_s1;

			left_s3  <= to_speed(lp_s2, flg_s2.neg, flg_s2.yzero);
			right_s3 <= to_speed(rp_s2, flg_s2.neg, flg_s2.yzero);
			flg_s3   <= flg_s2;
		end
	end

	assign out_valid   = vld_s3;
	assign left_speed  = left_s3;
	assign right_speed = right_s3;
	assign out_flags   = flg_s3;

endmodule

[rtl/core/joystick_to_differential_drive_core.sv]
// ----------------------------------------------------------------------------
// Joystick to differential drive mixer
// Turns a joystick sample into left and right motor speed commands.
// ----------------------------------------------------------------------------
// Usage:
// A sample word enters on the s_ group: tdata holds stick_x in bits 15:0 and
// stick_y in bits 31:16, both signed Q2.14. A result word leaves on the m_
// group: left_speed in bits 8:0 and right_speed in bits 17:9, signed.
// The link_up register is written through cfg_we and cfg_wdata. While it is 0
// every sample is taken and dropped with no result.
// Throughput is one word per cycle while m_tready allows. The pipeline has
// 6 + max(23, CORDIC_STEPS) stages, 29 at the default settings: three front
// stages for clamp, square and sum, one stage per square root bit or CORDIC
// step, and three for scaling.
// When the receiver holds m_tready low with a word waiting, the whole pipeline
// freezes and s_tready falls; nothing is dropped or repeated.
// Reset clears link_up and every valid bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "joystick_to_differential_drive_core_assert.svh"

module joystick_to_differential_drive_core #(
	parameter int TOP_SPEED    = jdd_pkg::TOP_SPEED_DEF,
	parameter int CORDIC_STEPS = jdd_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: link_up.
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	// Input words: stick_x [15:0], stick_y [31:16].
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	// Result words: left_speed [8:0], right_speed [17:9], zero fill [23:18].
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);

	logic                link_up_q;
	logic                adv;
	logic                fr_vld, it_vld;
	jdd_pkg::jdd_iter_t  fr_dat, it_dat;
	jdd_pkg::jdd_flags_t fr_flg, it_flg, res_flags;
	logic signed [jdd_pkg::SPEED_W-1:0] left_speed, right_speed;

	// Link register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_up_q <= 1'b0;
		end else if (cfg_we) begin
			link_up_q <= cfg_wdata;
		end
	end

	// The pipeline moves whenever the output stage is empty or being taken.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	jdd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (s_tvalid && link_up_q),
		.stick_x  ($signed(s_tdata[15:0])),
		.stick_y  ($signed(s_tdata[31:16])),
		.out_valid(fr_vld),
		.out_dat  (fr_dat),
		.out_flags(fr_flg)
	);

	jdd_iter #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_iter (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (fr_vld),
		.in_dat   (fr_dat),
		.in_flags (fr_flg),
		.out_valid(it_vld),
		.out_dat  (it_dat),
		.out_flags(it_flg)
	);

	jdd_back #(
		.TOP_SPEED(TOP_SPEED)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv),
		.in_valid   (it_vld),
		.in_dat     (it_dat),
		.in_flags   (it_flg),
		.out_valid  (m_tvalid),
		.left_speed (left_speed),
		.right_speed(right_speed),
		.out_flags  (res_flags)
	);

	// Result word packing.
	assign m_tdata = {6'b0, right_speed, left_speed};

	// A frozen pipeline keeps the iterative stage output unchanged.
	`JDD_ASSERT_NEXT(a_iter_hold, !adv, $stable(it_dat) && $stable(it_vld))
	// Stick on the left or centered, forward: the left motor is never faster.
	`JDD_ASSERT_IMP(a_left_turn, m_tvalid && !res_flags.neg && !res_flags.xpos, $signed(right_speed) >= $signed(left_speed))
	// Stick on the right, forward: the right motor is never faster.
	`JDD_ASSERT_IMP(a_right_turn, m_tvalid && !res_flags.neg && res_flags.xpos, $signed(left_speed) >= $signed(right_speed))
	// Backward stick gives no positive speed on either motor.
	`JDD_ASSERT_IMP(a_reverse, m_tvalid && res_flags.neg, !(left_speed > 0) && !(right_speed > 0))

endmodule

[dv/tb_joystick_to_differential_drive_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick mixer testbench
// Streams joystick samples into the mixer and checks each speed word against
// an in-bench prediction of the clamp, norm, CORDIC angle and scaling steps.
// The link_up register is toggled between phases, and both stream sides
// insert random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_joystick_to_differential_drive_core;

	import jdd_pkg::*;

	localparam int  SPEED_MAX    = TOP_SPEED_DEF;
	localparam int  N_STEPS      = CORDIC_STEPS_DEF;
	localparam int  DRAIN_CYCLES = 64;
	localparam int  LINK_ITEMS   = 120;
	localparam int  DOWN_ITEMS   = 30;
	localparam int  N_PHASES     = 7;
	localparam bit  LINK_DOWN    = 1'b0;
	localparam bit  LINK_UP      = 1'b1;
	localparam longint QUARTER   = 64'd1073741824;

	// atan(2^-i) in quarter turns, Q30.
	localparam longint ATAN_QT [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	// Axis values at and around the clamp limits, zero and the sign change.
	localparam logic [15:0] AXIS_EDGES [10] = '{
		16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h4001,
		16'hBFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h3FFF
	};

	// Phase plan for the random part.
	localparam bit LINK_PLAN [N_PHASES] = '{1, 1, 0, 1, 1, 0, 1};

	typedef struct {
		logic signed [SPEED_W-1:0] left;
		logic signed [SPEED_W-1:0] right;
	} speed_pair_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	logic [31:0] sample_q [$];
	speed_pair_t speed_q  [$];

	bit  link_on;
	bit  tx_idle;
	bit  rx_idle;
	bit  in_take;
	bit  out_take;
	int  tx_gap;
	int  rx_wait;
	int  items_sent;
	int  items_taken;
	int  fail_cnt;

	joystick_to_differential_drive_core #(
		.TOP_SPEED    (SPEED_MAX),
		.CORDIC_STEPS (N_STEPS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Integer square root, one result bit per pass.
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res;
		longint unsigned probe;
		res = 0;
		probe = 64'd1 << 46;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= res + probe) begin
				n = n - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res >>= 1;
			end
			probe >>= 2;
		end
		return res;
	endfunction

	// Stick angle in Q30 quarter turns, both magnitudes non-negative.
	function automatic longint quarter_turns(longint ax, longint ay);
		longint cx;
		longint cy;
		longint z;
		longint dx;
		longint dy;
		if (ay == 0)
			return 0;
		if (ax == 0)
			return QUARTER;
		cx = ax * 65536;
		cy = ay * 65536;
		z = 0;
		for (int i = 0; i < N_STEPS && i < 24; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx = cx + dx;
				cy = cy - dy;
				z = z + ATAN_QT[i];
			end else begin
				cx = cx - dx;
				cy = cy + dy;
				z = z - ATAN_QT[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > QUARTER)
			z = QUARTER;
		return z;
	endfunction

	// Floored, saturated speed from the norm and a Q30 factor.
	function automatic logic signed [SPEED_W-1:0] scale_speed(longint unsigned r,
			longint unsigned mul, bit neg);
		longint unsigned p;
		longint unsigned m;
		longint v;
		p = longint'(SPEED_MAX) * r * mul;
		if (neg) begin
			m = (p + ((64'd1 << 52) - 1)) >> 52;
			if (m > 256)
				m = 256;
			v = -longint'(m);
		end else begin
			m = p >> 52;
			if (m > 255)
				m = 255;
			v = longint'(m);
		end
		return v[SPEED_W-1:0];
	endfunction

	function automatic longint clamp_unit(logic signed [15:0] raw);
		longint v;
		v = raw;
		if (v > ONE_Q14)
			v = ONE_Q14;
		if (v < -ONE_Q14)
			v = -ONE_Q14;
		return v;
	endfunction

	// Expected speed pair for one sample word.
	function automatic speed_pair_t mix_speeds(logic [31:0] word);
		longint x;
		longint y;
		longint ax;
		longint ay;
		longint t;
		longint unsigned r;
		longint unsigned lmul;
		longint unsigned rmul;
		speed_pair_t res;
		x = clamp_unit(word[15:0]);
		y = clamp_unit(word[31:16]);
		res.left = '0;
		res.right = '0;
		if (y != 0) begin
			ax = (x < 0) ? -x : x;
			ay = (y < 0) ? -y : y;
			r = root_floor(longint'(x * x + y * y) << 16);
			t = quarter_turns(ax, ay);
			if (x > 0) begin
				lmul = QUARTER;
				rmul = t;
			end else begin
				lmul = t;
				rmul = QUARTER;
			end
			res.left = scale_speed(r, lmul, y < 0);
			res.right = scale_speed(r, rmul, y < 0);
		end
		return res;
	endfunction

	function automatic logic [15:0] pick_axis();
		case ($urandom_range(0, 9))
			0, 1, 2: return 16'($urandom);
			3:       return AXIS_EDGES[$urandom_range(0, 9)];
			4:       return 16'($urandom_range(0, 64) - 32);
			default: return 16'($urandom_range(0, 32768) - 16384);
		endcase
	endfunction

	task automatic push_xy(int x, int y);
		sample_q.push_back({16'(y), 16'(x)});
		items_sent++;
	endtask

	task automatic set_link(bit v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		link_on = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every sample is taken and every speed word has come back.
	task automatic settle();
		wait (items_taken == items_sent);
		wait (speed_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Sample driver: each word waits a drawn gap, then holds until taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_take)) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				s_tvalid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				s_tdata <= sample_q.pop_front();
				s_tvalid <= 1'b1;
				tx_gap <= tx_idle ? $urandom_range(0, 12) : 0;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: after each word taken, stall for a drawn count.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_take)
				rx_wait = rx_idle ? $urandom_range(0, 12) : 0;
			if (rx_wait > 0) begin
				m_tready <= 1'b0;
				rx_wait = rx_wait - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: predict on each sample taken, check each speed word taken.
	always @(posedge clk) begin
		speed_pair_t want;
		if (!arst_n) begin
			in_take <= 1'b0;
			out_take <= 1'b0;
		end else begin
			in_take <= s_tvalid && s_tready;
			out_take <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				if (link_on)
					speed_q.push_back(mix_speeds(s_tdata));
				items_taken++;
			end
			if (m_tvalid && m_tready) begin
				if (speed_q.size() == 0) begin
					$error("speed word 0x%06h arrived with none expected", m_tdata);
					fail_cnt++;
				end else begin
					want = speed_q.pop_front();
					if ($signed(m_tdata[8:0]) !== want.left) begin
						$error("left_speed: expected %0d, got %0d", want.left,
							$signed(m_tdata[8:0]));
						fail_cnt++;
					end
					if ($signed(m_tdata[17:9]) !== want.right) begin
						$error("right_speed: expected %0d, got %0d", want.right,
							$signed(m_tdata[17:9]));
						fail_cnt++;
					end
				end
			end
		end
	end

	// Stimulus and phase sequencing.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		link_on = LINK_DOWN;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Link down out of reset: samples are taken and dropped.
		for (int k = 0; k < 8; k++)
			push_xy(pick_axis(), pick_axis());
		settle();
		set_link(LINK_UP);

		// Directed corners: zero stick, clamp limits, zero y, zero x, tiny values.
		push_xy(0, 0);
		push_xy(16384, 16384);
		push_xy(-16384, -16384);
		push_xy(16384, -16384);
		push_xy(-16384, 16384);
		push_xy(32767, 32767);
		push_xy(-32768, -32768);
		push_xy(16385, -16385);
		push_xy(5000, 0);
		push_xy(-32768, 0);
		push_xy(0, 16384);
		push_xy(0, -16384);
		push_xy(0, 1);
		push_xy(0, -1);
		push_xy(1, 1);
		push_xy(-1, -1);
		push_xy(1, -1);
		push_xy(16384, 1);
		push_xy(-16384, -1);
		push_xy(12000, 9000);
		push_xy(-7000, 11000);
		push_xy(16383, -16383);
		push_xy(16'h5555, 16'hAAAA);
		push_xy(16'hAAAA, 16'h5555);
		settle();

		// Random phases with a fresh register write and idle pattern each.
		for (int p = 0; p < N_PHASES; p++) begin
			tx_idle = p[0];
			rx_idle = p[1];
			set_link(LINK_PLAN[p]);
			for (int k = 0; k < (LINK_PLAN[p] ? LINK_ITEMS : DOWN_ITEMS); k++)
				push_xy(pick_axis(), pick_axis());
			settle();
		end

		if (fail_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Hard limit on run time.
	initial begin
		#5ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
